FILE: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types and codes for the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int ADDR_W   = 40;
  localparam int LEN_W    = 40;
  localparam int RTYPE_W  = 4;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int PADDR_W  = 28;
  localparam int COUNT_W  = 17;
  localparam int WORD_W   = 64;
  localparam int BIT_W    = 6;
  localparam int POP_W    = 7;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNALIGNED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd4;

  localparam logic [RTYPE_W-1:0] REGION_AVAILABLE = 4'd1;

  typedef enum logic [1:0] {
    WOP_SET,
    WOP_CLEAR,
    WOP_TAKE
  } wop_t;

  typedef struct packed {
    wop_t             op;
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
  } wu_ctrl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_A_RD,
    S_A_CHK,
    S_F_RD,
    S_F_CHK,
    S_R_SUM,
    S_R_BOUND,
    S_R_RANGE,
    S_R_RD,
    S_R_MOD,
    S_R_CNT,
    S_DONE
  } state_t;

endpackage

FILE: sv/bpa_map_ram.sv
// ----------------------------------------------------------------------------
// bpa_map_ram
// free bitmap store, one write port and one registered read port
// ----------------------------------------------------------------------------
module bpa_map_ram
  import bpa_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bpa_word_unit.sv
// ----------------------------------------------------------------------------
// bpa_word_unit
// shared bitmap word unit: range set/clear with popcount, lowest free bit take
// ----------------------------------------------------------------------------
module bpa_word_unit
  import bpa_pkg::*;
(
  input  wu_ctrl_t          ctrl,
  input  logic [WORD_W-1:0] word,
  output logic [WORD_W-1:0] new_word,
  output logic [POP_W-1:0]  count,
  output logic [BIT_W-1:0]  low
);

  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] iso;
  logic [WORD_W-1:0] pop_in;
  logic [3:0]        grp [8];
  logic [POP_W-1:0]  pop;

  assign mask = ({WORD_W{1'b1}} << ctrl.lo) & ({WORD_W{1'b1}} >> (6'd63 - ctrl.hi));
  assign iso  = word & (~word + 64'd1);

  always_comb begin
    low = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (iso[i]) begin
        low = low | BIT_W'(i);
      end
    end
  end

  assign pop_in = (ctrl.op == WOP_CLEAR) ? (mask & word) : (mask & ~word);

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp[g] = grp[g] + 4'(pop_in[g*8+b]);
      end
    end
  end

  always_comb begin
    pop = '0;
    for (int g = 0; g < 8; g++) begin
      pop = pop + POP_W'(grp[g]);
    end
  end

  always_comb begin
    case (ctrl.op)
      WOP_SET: begin
        new_word = word | mask;
        count    = pop;
      end
      WOP_CLEAR: begin
        new_word = word & ~mask;
        count    = pop;
      end
      WOP_TAKE: begin
        new_word = word & ~iso;
        count    = POP_W'(|word);
      end
      default: begin
        new_word = word;
        count    = '0;
      end
    endcase
  end

endmodule

FILE: sv/bitmap_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// physical page allocator over a free bitmap with free and total page counts
// ----------------------------------------------------------------------------
// a request is taken at a rising edge with start high and busy low; kind picks
// alloc, free, add region or reserve. exactly one result follows: done is high
// for one cycle with status, page_address, free_count and total_count valid.
// the receiver cannot stall, so the result is lost if not taken in that cycle.
// busy stays high from the accepted request until the done cycle has passed,
// so a new request can be taken in the cycle after done. free checks the
// address and sets the page bit in its bitmap word, or skips to done if the
// check fails. alloc reads and checks one bitmap word at a time from the
// lowest word that may hold a free page, or skips to done when no page is
// known to be free. add region and reserve sum and bound the page range, then
// read, modify and count each word it touches, or, for an add of a region that
// is not available, skip to done. each word gets one bitmap read and one pass
// through the shared word unit. after reset the bitmap is swept to all used,
// one word a cycle, over all words (1024 by default), busy high; counts are 0.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES  = 65536,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [ADDR_W-1:0]   address,
  input  logic [LEN_W-1:0]    length,
  input  logic [RTYPE_W-1:0]  region_type,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [PADDR_W-1:0]  page_address,
  output logic [COUNT_W-1:0]  free_count,
  output logic [COUNT_W-1:0]  total_count
);

  localparam int MAP_WORDS = (MAX_PAGES + 63) / 64;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int HW        = $clog2(MAP_WORDS + 1);
  localparam int PW        = $clog2(MAX_PAGES + 1);
  localparam int SUM_W     = ADDR_W + 2;
  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

  state_t state, state_next;

  logic [KIND_W-1:0]   kind_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [LEN_W-1:0]    len_q;
  logic [RTYPE_W-1:0]  rtype_q;
  logic [SUM_W-1:0]    sum_end;
  logic [SUM_W-1:0]    sum_first;
  logic [PW-1:0]       first_pg;
  logic [PW-1:0]       last_pg;
  logic [PW-1:0]       last_m1;
  logic [AW-1:0]       cur_w;
  logic [HW-1:0]       hint;
  logic [POP_W-1:0]    pc;
  logic [PW-1:0]       free_cnt;
  logic [PW-1:0]       total_cnt;
  logic [STATUS_W-1:0] status_q;
  logic [PADDR_W-1:0]  paddr_q;

  logic [WORD_W-1:0] rdata;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;
  wu_ctrl_t          wu_ctrl;
  logic [WORD_W-1:0] wu_new;
  logic [POP_W-1:0]  wu_count;
  logic [BIT_W-1:0]  wu_low;

  logic [AW-1:0]  first_w;
  logic [AW-1:0]  last_w;
  logic [AW-1:0]  free_w;
  logic           unaligned;
  logic           out_range;
  logic           alloc_ok;
  logic           last_word;
  logic [SUM_W-1:0] last_raw;
  logic [SUM_W-1:0] first_raw;
  logic [PW:0]    free_inc;
  logic [PW:0]    free_add;
  logic [PW:0]    total_add;

  assign first_w   = AW'(first_pg >> 6);
  assign last_w    = AW'(last_m1 >> 6);
  assign free_w    = AW'(addr_q >> (PAGE_SHIFT + 6));
  assign unaligned = (addr_q & PAGE_MASK) != '0;
  assign out_range = (addr_q >> PAGE_SHIFT) >= ADDR_W'(MAX_PAGES);
  assign alloc_ok  = (wu_count != '0) &&
                     ((PW+1)'({cur_w, wu_low}) < (PW+1)'(MAX_PAGES));
  assign last_word = cur_w == AW'(MAP_WORDS - 1);
  assign last_raw  = (kind_q == KIND_RESERVE) ?
                     ((sum_end + SUM_W'(PAGE_MASK)) >> PAGE_SHIFT) : (sum_end >> PAGE_SHIFT);
  assign first_raw = (kind_q == KIND_RESERVE) ?
                     SUM_W'(addr_q >> PAGE_SHIFT) : (sum_first >> PAGE_SHIFT);
  assign free_inc  = {1'b0, free_cnt} + (PW+1)'(1);
  assign free_add  = {1'b0, free_cnt} + (PW+1)'(pc);
  assign total_add = {1'b0, total_cnt} + (PW+1)'(pc);

  bpa_map_ram #(
    .DEPTH(MAP_WORDS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(cur_w),
    .wdata(mem_wdata),
    .raddr(cur_w),
    .rdata(rdata)
  );

  bpa_word_unit u_word (
    .ctrl    (wu_ctrl),
    .word    (rdata),
    .new_word(wu_new),
    .count   (wu_count),
    .low     (wu_low)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mem_we       = 1'b0;
    mem_wdata    = wu_new;
    wu_ctrl.op   = (kind_q == KIND_RESERVE) ? WOP_CLEAR : WOP_SET;
    wu_ctrl.lo   = (cur_w == first_w) ? first_pg[BIT_W-1:0] : '0;
    wu_ctrl.hi   = (cur_w == last_w) ? last_m1[BIT_W-1:0] : '1;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (last_word) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (kind_q)
          KIND_ALLOC: begin
            state_next = (hint == HW'(MAP_WORDS)) ? S_DONE : S_A_RD;
          end
          KIND_FREE: begin
            state_next = (unaligned || out_range) ? S_DONE : S_F_RD;
          end
          KIND_ADD: begin
            state_next = (rtype_q == REGION_AVAILABLE) ? S_R_SUM : S_DONE;
          end
          default: begin
            state_next = S_R_SUM;
          end
        endcase
      end
      S_A_RD: begin
        state_next = S_A_CHK;
      end
      S_A_CHK: begin
        wu_ctrl.op = WOP_TAKE;
        wu_ctrl.lo = '0;
        wu_ctrl.hi = '1;
        mem_we     = alloc_ok;
        if (wu_count != '0 || last_word) begin
          state_next = S_DONE;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_F_RD: begin
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        wu_ctrl.op = WOP_SET;
        wu_ctrl.lo = addr_q[PAGE_SHIFT +: BIT_W];
        wu_ctrl.hi = addr_q[PAGE_SHIFT +: BIT_W];
        mem_we     = 1'b1;
        state_next = S_DONE;
      end
      S_R_SUM: begin
        state_next = S_R_BOUND;
      end
      S_R_BOUND: begin
        state_next = S_R_RANGE;
      end
      S_R_RANGE: begin
        state_next = (first_pg >= last_pg) ? S_DONE : S_R_RD;
      end
      S_R_RD: begin
        state_next = S_R_MOD;
      end
      S_R_MOD: begin
        mem_we     = 1'b1;
        state_next = S_R_CNT;
      end
      S_R_CNT: begin
        state_next = (cur_w == last_w) ? S_DONE : S_R_RD;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_w     <= '0;
      hint      <= '0;
      free_cnt  <= '0;
      total_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (!last_word) begin
            cur_w <= cur_w + AW'(1);
          end
        end
        S_DECODE: begin
          if (kind_q == KIND_ALLOC) begin
            cur_w <= AW'(hint);
          end else begin
            cur_w <= free_w;
          end
        end
        S_A_CHK: begin
          if (alloc_ok) begin
            hint <= HW'(cur_w);
            if (free_cnt != '0) begin
              free_cnt <= free_cnt - PW'(1);
            end
          end else if (wu_count == '0) begin
            if (last_word) begin
              hint <= HW'(MAP_WORDS);
            end else begin
              cur_w <= cur_w + AW'(1);
            end
          end
        end
        S_F_CHK: begin
          if (wu_count != '0) begin
            if (free_inc <= (PW+1)'(MAX_PAGES)) begin
              free_cnt <= free_inc[PW-1:0];
            end
            if (HW'(cur_w) < hint) begin
              hint <= HW'(cur_w);
            end
          end
        end
        S_R_RANGE: begin
          cur_w <= first_w;
          if (kind_q == KIND_ADD && first_pg < last_pg && HW'(first_w) < hint) begin
            hint <= HW'(first_w);
          end
        end
        S_R_CNT: begin
          if (kind_q == KIND_ADD) begin
            free_cnt  <= (free_add > (PW+1)'(MAX_PAGES)) ?
                         PW'(MAX_PAGES) : free_add[PW-1:0];
            total_cnt <= (total_add > (PW+1)'(MAX_PAGES)) ?
                         PW'(MAX_PAGES) : total_add[PW-1:0];
          end else begin
            free_cnt  <= (free_cnt > PW'(pc)) ? (free_cnt - PW'(pc)) : '0;
          end
          if (cur_w != last_w) begin
            cur_w <= cur_w + AW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request payload and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kind_q   <= kind;
        addr_q   <= address;
        len_q    <= length;
        rtype_q  <= region_type;
        status_q <= ST_OK;
        paddr_q  <= '0;
      end
      S_DECODE: begin
        if (kind_q == KIND_ALLOC && hint == HW'(MAP_WORDS)) begin
          status_q <= ST_OOM;
        end else if (kind_q == KIND_FREE && unaligned) begin
          status_q <= ST_UNALIGNED;
        end else if (kind_q == KIND_FREE && out_range) begin
          status_q <= ST_RANGE;
        end
      end
      S_A_CHK: begin
        if (alloc_ok) begin
          paddr_q <= PADDR_W'({cur_w, wu_low, {PAGE_SHIFT{1'b0}}});
        end else if (wu_count != '0 || last_word) begin
          status_q <= ST_OOM;
        end
      end
      S_F_CHK: begin
        if (wu_count == '0) begin
          status_q <= ST_DOUBLE;
        end
      end
      S_R_SUM: begin
        sum_end   <= SUM_W'(addr_q) + SUM_W'(len_q);
        sum_first <= SUM_W'(addr_q) + SUM_W'(PAGE_MASK);
      end
      S_R_BOUND: begin
        last_pg  <= (last_raw > SUM_W'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(last_raw);
        first_pg <= (first_raw > SUM_W'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(first_raw);
      end
      S_R_RANGE: begin
        last_m1 <= last_pg - PW'(1);
      end
      S_R_MOD: begin
        pc <= wu_count;
      end
      default: begin
      end
    endcase
  end

  assign busy         = state != S_IDLE;
  assign done         = state == S_DONE;
  assign status       = status_q;
  assign page_address = paddr_q;
  assign free_count   = COUNT_W'(free_cnt);
  assign total_count  = COUNT_W'(total_cnt);

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= PW'(MAX_PAGES) && total_cnt <= PW'(MAX_PAGES))
    else $error("page count beyond page limit");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request transfer not followed by busy");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> page_address == '0)
    else $error("page address set on a failed request");

endmodule
